/* rtl/core/linear_system_solver_top_macros.svh */
// Assertion macros for the linear system solver.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef LINEAR_SYSTEM_SOLVER_TOP_MACROS_SVH
`define LINEAR_SYSTEM_SOLVER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lss_pkg.sv */
// Shared types and constants of the linear system solver.
// No dependencies; imported by every module of the block except lss_ram.
package lss_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int VAL_W         = 32;
    localparam int Q_FRAC        = 16;
    localparam int DIV_W         = VAL_W + Q_FRAC;
    localparam int DIV_CW        = $clog2(DIV_W);
    localparam int ORDER_W       = 4;
    localparam int IDX_W         = 3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

    // Source of the word written into the matrix store.
    typedef enum logic [1:0] {
        WS_IN,
        WS_UPD,
        WS_QUO
    } t_wsel;

    // Operand register that takes the word read in the previous cycle.
    typedef enum logic [1:0] {
        CP_NONE,
        CP_DEN,
        CP_T,
        CP_X
    } t_cap;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        t_wsel              wr_sel;
        t_cap               cap;
        logic               div_go;
        logic               mul_go;
        logic               err_clr;
        logic               out_load;
        logic               out_last;
        logic [IDX_W-1:0]   out_idx;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_sts;

endpackage

/* rtl/core/lss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lss_div.sv */
// Iterative Q16.16 divider: one quotient bit per cycle, saturated result.
// Depends on lss_pkg.
module lss_div import lss_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VAL_W-1:0] i_num,
    input  logic signed [VAL_W-1:0] i_den,
    output logic                    o_busy,
    output logic signed [VAL_W-1:0] o_quo
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [VAL_W:0]    r_rem;
    logic [DIV_W-1:0]  r_acc;
    logic [VAL_W-1:0]  r_dvs;
    logic              r_neg;

    logic [VAL_W-1:0]  num_mag;
    logic [VAL_W-1:0]  den_mag;
    logic [VAL_W:0]    rem_sh;
    logic              q_bit;
    logic [VAL_W:0]    rem_nx;

    assign num_mag = i_num[VAL_W-1] ? VAL_W'(-i_num) : VAL_W'(i_num);
    assign den_mag = i_den[VAL_W-1] ? VAL_W'(-i_den) : VAL_W'(i_den);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {r_rem[VAL_W-1:0], r_acc[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend shifts out as the quotient shifts in. A zero divisor gives zero.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= den_mag;
            if (i_den == '0) begin
                r_acc <= '0;
                r_neg <= 1'b0;
            end else begin
                r_acc <= {num_mag, {Q_FRAC{1'b0}}};
                r_neg <= i_num[VAL_W-1] ^ i_den[VAL_W-1];
            end
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_acc <= {r_acc[DIV_W-2:0], q_bit};
        end
    end

    // Apply the sign and saturate to 32 bits.
    always_comb begin
        if (!r_neg) begin
            if (r_acc > DIV_W'(33'h0_7FFF_FFFF)) begin
                o_quo = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                o_quo = r_acc[VAL_W-1:0];
            end
        end else begin
            if (r_acc > DIV_W'(33'h0_8000_0000)) begin
                o_quo = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                o_quo = -r_acc[VAL_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/core/lss_datapath.sv */
// Datapath: matrix store, operand registers, multiplier, divider, result register.
// Depends on lss_pkg, lss_ram and lss_div.
module lss_datapath import lss_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    localparam int DEPTH    = MAX_ORDER * (MAX_ORDER + 1),
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [AW-1:0]           i_raddr,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [VAL_W-1:0] i_coefficient,
    output t_sts                    o_sts,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_solution,
    output logic [IDX_W-1:0]        o_unknown_index,
    output logic                    o_last,
    output logic                    o_singular
);

    logic signed [VAL_W-1:0]   rdata;
    logic signed [VAL_W-1:0]   wdata;
    logic signed [VAL_W-1:0]   quo;
    logic                      div_busy;
    logic signed [VAL_W-1:0]   r_den;
    logic signed [VAL_W-1:0]   r_t;
    logic signed [VAL_W-1:0]   r_x;
    logic signed [2*VAL_W-1:0] r_prod;
    logic                      r_err;
    logic                      r_oval;
    logic signed [VAL_W-1:0]   r_sol;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_last;
    logic                      r_sing;
    logic signed [2*VAL_W-1:0] pq;
    logic signed [2*VAL_W-1:0] diff;
    logic signed [VAL_W-1:0]   upd;

    lss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    lss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (rdata),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // Operand capture and the registered product of factor and pivot-row entry.
    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            CP_DEN:  r_den <= rdata;
            CP_T:    r_t   <= rdata;
            CP_X:    r_x   <= rdata;
            default: ;
        endcase
        if (i_cmd.mul_go) begin
            r_prod <= quo * r_t;
        end
    end

    // Product scaled back to Q16.16 with truncation toward zero, then x minus it.
    always_comb begin
        pq = (r_prod >>> Q_FRAC)
           + ((r_prod[2*VAL_W-1] && (r_prod[Q_FRAC-1:0] != '0)) ? 64'sd1 : 64'sd0);
        diff = (2*VAL_W)'(r_x) - pq;
        if (diff > (2*VAL_W)'(32'sh7FFF_FFFF)) begin
            upd = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (diff < -(2*VAL_W)'(33'sh0_8000_0000)) begin
            upd = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            upd = diff[VAL_W-1:0];
        end
    end

    // Store write data.
    always_comb begin
        case (i_cmd.wr_sel)
            WS_IN:   wdata = i_coefficient;
            WS_UPD:  wdata = upd;
            WS_QUO:  wdata = quo;
            default: wdata = i_coefficient;
        endcase
    end

    // Zero-pivot flag for the system being solved.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.err_clr) begin
            r_err <= 1'b0;
        end else if (i_cmd.div_go && (r_den == '0)) begin
            r_err <= 1'b1;
        end
    end

    // Result register; the word waits here until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sol  <= rdata;
            r_idx  <= i_cmd.out_idx;
            r_last <= i_cmd.out_last;
            r_sing <= r_err;
        end
    end

    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_full  = r_oval;
    assign o_valid         = r_oval;
    assign o_solution      = r_sol;
    assign o_unknown_index = r_idx;
    assign o_last          = r_last;
    assign o_singular      = r_sing;

endmodule

/* rtl/core/lss_ctrl.sv */
// Controller: load sequencing, elimination loop counters and result emission.
// Depends on lss_pkg.
module lss_ctrl import lss_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    localparam int MP1      = MAX_ORDER + 1,
    localparam int AW       = $clog2(MAX_ORDER * MP1),
    localparam int CW       = $clog2(MP1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ORDER_W-1:0] i_cfg_order,
    input  t_sts               i_sts,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_raddr,
    output logic [AW-1:0]      o_waddr
);

    typedef enum logic [11:0] {
        S_LOAD = 12'b0000_0000_0001,
        S_RDD  = 12'b0000_0000_0010,
        S_RDN  = 12'b0000_0000_0100,
        S_DIV  = 12'b0000_0000_1000,
        S_DWT  = 12'b0000_0001_0000,
        S_WQ   = 12'b0000_0010_0000,
        S_RDT  = 12'b0000_0100_0000,
        S_RDX  = 12'b0000_1000_0000,
        S_MUL  = 12'b0001_0000_0000,
        S_WU   = 12'b0010_0000_0000,
        S_ERD  = 12'b0100_0000_0000,
        S_ELD  = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_BWD,
        PH_FIN
    } t_phase;

    t_state             r_state, n_state;
    t_phase             r_ph, n_ph;
    logic [ORDER_W-1:0] r_order, n_order;
    logic [CW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      n_act;
    logic [CW-1:0]      nm1;
    logic               in_acc;
    logic               cfg_acc;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] row,
                                             input logic [CW-1:0] col);
        f_addr = AW'(int'(row) * MP1 + int'(col));
    endfunction

    // Order in use, clamped to the built range.
    always_comb begin
        if (r_order == '0) begin
            n_act = CW'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            n_act = CW'(MAX_ORDER);
        end else begin
            n_act = CW'(r_order);
        end
        nm1 = n_act - 1'b1;
    end

    assign o_stall     = (r_state != S_LOAD);
    assign o_cfg_ready = (r_state == S_LOAD);
    assign in_acc      = i_valid && !o_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // Next state, loop counters and datapath commands.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_order = r_order;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        o_raddr = '0;
        o_waddr = '0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_IN;
                    o_waddr      = f_addr(r_row, r_col);
                    if (r_col != n_act) begin
                        n_col = r_col + 1'b1;
                    end else if (r_row != nm1) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col         = '0;
                        n_row         = '0;
                        o_cmd.err_clr = 1'b1;
                        n_state       = S_RDD;
                        n_k           = '0;
                        if (n_act > CW'(1)) begin
                            n_ph = PH_FWD;
                            n_i  = CW'(1);
                            n_j  = CW'(1);
                        end else begin
                            n_ph = PH_FIN;
                            n_i  = '0;
                        end
                    end
                end
                if (cfg_acc) begin
                    n_order       = i_cfg_order;
                    n_row         = '0;
                    n_col         = '0;
                    o_cmd.err_clr = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_RDD: begin
                o_cmd.rd_en = 1'b1;
                o_raddr     = (r_ph == PH_FIN) ? f_addr(r_i, r_i) : f_addr(r_k, r_k);
                n_state     = S_RDN;
            end
            S_RDN: begin
                o_cmd.cap   = CP_DEN;
                o_cmd.rd_en = 1'b1;
                o_raddr     = (r_ph == PH_FIN) ? f_addr(r_i, n_act) : f_addr(r_i, r_k);
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DWT;
            end
            S_DWT: begin
                if (!i_sts.div_busy) begin
                    n_state = (r_ph == PH_FIN) ? S_WQ : S_RDT;
                end
            end
            S_WQ: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_QUO;
                o_waddr      = f_addr(r_i, n_act);
                if (r_i == nm1) begin
                    n_i     = '0;
                    n_state = S_ERD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RDD;
                end
            end
            S_RDT: begin
                o_cmd.rd_en = 1'b1;
                o_raddr     = f_addr(r_k, r_j);
                n_state     = S_RDX;
            end
            S_RDX: begin
                o_cmd.cap   = CP_T;
                o_cmd.rd_en = 1'b1;
                o_raddr     = f_addr(r_i, r_j);
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.cap    = CP_X;
                o_cmd.mul_go = 1'b1;
                n_state      = S_WU;
            end
            S_WU: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_UPD;
                o_waddr      = f_addr(r_i, r_j);
                n_state      = S_RDD;
                if (r_ph == PH_FWD) begin
                    if (r_j != n_act) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_RDT;
                    end else if (r_i != nm1) begin
                        n_i = r_i + 1'b1;
                        n_j = r_k + 1'b1;
                    end else if ((r_k + CW'(2)) < n_act) begin
                        n_k = r_k + 1'b1;
                        n_i = r_k + CW'(2);
                        n_j = r_k + CW'(2);
                    end else begin
                        n_ph = PH_BWD;
                        n_k  = nm1;
                        n_i  = '0;
                        n_j  = n_act;
                    end
                end else begin
                    if ((r_i + 1'b1) < r_k) begin
                        n_i = r_i + 1'b1;
                    end else if (r_k > CW'(1)) begin
                        n_k = r_k - 1'b1;
                        n_i = '0;
                    end else begin
                        n_ph = PH_FIN;
                        n_i  = '0;
                    end
                end
            end
            S_ERD: begin
                if (!i_sts.out_full) begin
                    o_cmd.rd_en = 1'b1;
                    o_raddr     = f_addr(r_i, n_act);
                    n_state     = S_ELD;
                end
            end
            S_ELD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_idx  = IDX_W'(r_i);
                o_cmd.out_last = (r_i == nm1);
                if (r_i == nm1) begin
                    n_state = S_LOAD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ph    <= PH_FWD;
            r_order <= ORDER_RESET;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_order <= n_order;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

endmodule

/* rtl/core/linear_system_solver_top.sv */
// Top level of the linear system solver: controller, datapath and checks.
// Depends on lss_pkg, lss_ctrl, lss_datapath and the assertion macro header.
//
// Solves an n-by-n system A x = b in signed Q16.16 by Gauss-Jordan elimination
// without pivoting. The augmented matrix is loaded one word per cycle in
// row-major order, each row's right-hand side after its n coefficients, so a
// system takes n*(n+1) words. After the last word the input stalls while
// a single shared datapath works through the elimination out of one RAM:
// every division (n*(n-1)/2 forward, n*(n-1)/2 backward, n final) runs in the
// bit-serial divider, and every multiply-subtract update, forward or backward,
// shares one multiplier. Then the n results are sent, each once the result
// register is free, with the last marked; a zero pivot flags every result as
// singular. The order register may be written whenever the input is not stalled.
`include "linear_system_solver_top_macros.svh"

module linear_system_solver_top import lss_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_coefficient,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ORDER_W-1:0]      i_cfg_order,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_solution,
    output logic [IDX_W-1:0]        o_unknown_index,
    output logic                    o_last,
    output logic                    o_singular
);

    localparam int AW = $clog2(MAX_ORDER * (MAX_ORDER + 1));

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    lss_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_order (i_cfg_order),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_raddr     (raddr),
        .o_waddr     (waddr)
    );

    lss_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_raddr         (raddr),
        .i_waddr         (waddr),
        .i_coefficient   (i_coefficient),
        .o_sts           (sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_solution      (o_solution),
        .o_unknown_index (o_unknown_index),
        .o_last          (o_last),
        .o_singular      (o_singular)
    );

    // Configuration is accepted only while coefficient words can be accepted too.
    `LSS_ASSERT_NOW(a_cfg_when_loading, o_cfg_ready, !o_stall, "config ready while busy")
    // No further result follows the last one until a new system is loaded.
    `LSS_ASSERT_NEXT(a_quiet_after_last, o_valid && !i_stall && o_last, !o_valid, "result after last")

endmodule
